[hdl/assert_macros.svh]
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Invariant checked at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("assertion failed");

// Antecedent/consequent check, same-cycle implication.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Antecedent/consequent check, next-cycle implication.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

[hdl/bmhq_pkg.sv]
`default_nettype none

package bmhq_pkg;

   localparam int KEY_W     = 32;
   localparam int STAT_W    = 2;
   localparam int CNT_W     = 7;
   localparam int LIMIT_W   = 7;
   localparam int DEPTH_DEF = 64;

   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 7'd64;

   localparam logic OP_INSERT  = 1'b0;
   localparam logic OP_EXTRACT = 1'b1;

   localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
   localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
   localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

   localparam logic signed [KEY_W-1:0] EMPTY_KEY = -32'sd1;

   // Broadcast command to every cell of the sorted chain.
   typedef struct packed {
      logic                    ins;
      logic                    ext;
      logic signed [KEY_W-1:0] key;
   } cmd_type;

endpackage

`default_nettype wire

[hdl/bmhq_cell.sv]
`default_nettype none

module bmhq_cell (
   input  wire logic                              clock,
   input  wire bmhq_pkg::cmd_type                 cmd,
   input  wire logic                              occ,
   input  wire logic signed [bmhq_pkg::KEY_W-1:0] prev_val,
   input  wire logic                              prev_lt,
   input  wire logic signed [bmhq_pkg::KEY_W-1:0] next_val,
   output logic signed [bmhq_pkg::KEY_W-1:0]      val,
   output logic                                   lt
);
   import bmhq_pkg::*;

   logic signed [KEY_W-1:0] val_ff;
   logic signed [KEY_W-1:0] val_in;

   // Empty slots act as +infinity so the new key lands at the tail.
   assign lt  = !occ || (cmd.key < val_ff);
   assign val = val_ff;

   always_comb begin
      val_in = val_ff;
      priority if (cmd.ext) begin
         val_in = next_val;
      end else if (cmd.ins) begin
         if (prev_lt) begin
            val_in = prev_val;
         end else if (lt) begin
            val_in = cmd.key;
         end
      end
   end

   always_ff @(posedge clock) begin
      val_ff <= val_in;
   end

endmodule

`default_nettype wire

[hdl/bmhq_ctrl.sv]
`default_nettype none

`include "assert_macros.svh"

module bmhq_ctrl #(
   parameter int DEPTH = bmhq_pkg::DEPTH_DEF,
   parameter int FW    = $clog2(DEPTH + 1)
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               start,
   output logic                                    busy,
   input  wire logic                               req_op,
   input  wire logic signed [bmhq_pkg::KEY_W-1:0]  req_key_in,
   input  wire logic                               csr_we,
   input  wire logic [bmhq_pkg::LIMIT_W-1:0]       csr_wdata,
   input  wire logic signed [bmhq_pkg::KEY_W-1:0]  head_val,
   output bmhq_pkg::cmd_type                       cmd,
   output logic [FW-1:0]                           fill,
   output logic                                    rsp_valid,
   output logic signed [bmhq_pkg::KEY_W-1:0]       rsp_key_out,
   output logic [bmhq_pkg::STAT_W-1:0]             rsp_status,
   output logic [bmhq_pkg::CNT_W-1:0]              rsp_count
);
   import bmhq_pkg::*;

   localparam int CW = (FW > LIMIT_W) ? FW : LIMIT_W;
   localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

   logic                  busy_ff;
   logic [LIMIT_W-1:0]    limit_ff;
   logic [FW-1:0]         fill_ff, fill_in;
   logic                  valid_ff;
   logic signed [KEY_W-1:0] key_ff, key_in;
   logic [STAT_W-1:0]     stat_ff, stat_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;

   logic          accept;
   logic [CW-1:0] lim_ext, eff_lim, fill_ext, fill_in_ext;
   logic          full, empty;

   assign accept   = start && !busy_ff;
   assign lim_ext  = CW'(limit_ff);
   assign eff_lim  = (lim_ext > DEPTH_C) ? DEPTH_C : lim_ext;
   assign fill_ext = CW'(fill_ff);
   assign full     = fill_ext >= eff_lim;
   assign empty    = fill_ff == '0;

   always_comb begin
      cmd.ins = 1'b0;
      cmd.ext = 1'b0;
      cmd.key = req_key_in;
      fill_in = fill_ff;
      key_in  = '0;
      stat_in = ST_OK;
      if (accept) begin
         unique case (req_op)
            OP_INSERT: begin
               if (full) begin
                  stat_in = ST_FULL;
               end else begin
                  cmd.ins = 1'b1;
                  fill_in = fill_ff + FW'(1);
               end
            end
            OP_EXTRACT: begin
               if (empty) begin
                  key_in  = EMPTY_KEY;
                  stat_in = ST_EMPTY;
               end else begin
                  cmd.ext = 1'b1;
                  key_in  = head_val;
                  fill_in = fill_ff - FW'(1);
               end
            end
            default: begin
               stat_in = ST_OK;
            end
         endcase
      end
      fill_in_ext = CW'(fill_in);
      cnt_in      = fill_in_ext[CNT_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b1;
         limit_ff <= LIMIT_RESET;
         fill_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         busy_ff  <= 1'b0;
         if (csr_we) begin
            limit_ff <= csr_wdata;
         end
         fill_ff  <= fill_in;
         valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         key_ff  <= key_in;
         stat_ff <= stat_in;
         cnt_ff  <= cnt_in;
      end
   end

   assign busy        = busy_ff;
   assign fill        = fill_ff;
   assign rsp_valid   = valid_ff;
   assign rsp_key_out = key_ff;
   assign rsp_status  = stat_ff;
   assign rsp_count   = cnt_ff;

   `ASSERT_ALWAYS(a_fill_bound, clock, reset, fill_ext <= DEPTH_C)
   `ASSERT_NEXT(a_one_rsp, clock, reset, accept, rsp_valid)
   `ASSERT_NEXT(a_full_holds, clock, reset, accept && stat_in == ST_FULL, $stable(fill_ff))
   `ASSERT_IMPLIES(a_no_both, clock, reset, 1'b1, !(cmd.ins && cmd.ext))

endmodule

`default_nettype wire

[hdl/binary_min_heap_queue_core.sv]
`default_nettype none

// Min priority queue of signed 32-bit keys, kept as a sorted chain of DEPTH
// cells with the minimum in the first cell. A request (insert or extract
// minimum) is taken on any clock with start high and busy low; busy is high
// only in reset and until the first clock edge after it, so one request per
// clock is accepted. Every request gets exactly one response, on rsp_valid
// for a single cycle in the clock after acceptance; the receiver cannot stall
// it and must take it then. Each cell makes one key compare per request
// against the broadcast key. csr_wdata sets the capacity limit (saturated
// at DEPTH); write it only while no request is in flight.
module binary_min_heap_queue_core #(
   parameter int DEPTH = bmhq_pkg::DEPTH_DEF
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               start,
   output logic                                    busy,
   input  wire logic                               req_op,
   input  wire logic signed [bmhq_pkg::KEY_W-1:0]  req_key_in,
   input  wire logic                               csr_we,
   input  wire logic [bmhq_pkg::LIMIT_W-1:0]       csr_wdata,
   output logic                                    rsp_valid,
   output logic signed [bmhq_pkg::KEY_W-1:0]       rsp_key_out,
   output logic [bmhq_pkg::STAT_W-1:0]             rsp_status,
   output logic [bmhq_pkg::CNT_W-1:0]              rsp_count
);
   import bmhq_pkg::*;

   localparam int FW = $clog2(DEPTH + 1);

   cmd_type                 cmd;
   logic [FW-1:0]           fill;
   logic signed [KEY_W-1:0] val [DEPTH];
   logic                    lt  [DEPTH];

   bmhq_ctrl #(
      .DEPTH (DEPTH),
      .FW    (FW)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_op      (req_op),
      .req_key_in  (req_key_in),
      .csr_we      (csr_we),
      .csr_wdata   (csr_wdata),
      .head_val    (val[0]),
      .cmd         (cmd),
      .fill        (fill),
      .rsp_valid   (rsp_valid),
      .rsp_key_out (rsp_key_out),
      .rsp_status  (rsp_status),
      .rsp_count   (rsp_count)
   );

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      localparam logic [FW-1:0] IDX = FW'(i);
      logic signed [KEY_W-1:0] pv, nv;
      logic                    pl;
      logic                    occ;

      assign occ = IDX < fill;

      if (i == 0) begin : g_first
         assign pv = cmd.key;
         assign pl = 1'b0;
      end else begin : g_mid
         assign pv = val[i-1];
         assign pl = lt[i-1];
      end

      if (i == DEPTH - 1) begin : g_last
         assign nv = val[i];
      end else begin : g_next
         assign nv = val[i+1];
      end

      bmhq_cell u_cell (
         .clock    (clock),
         .cmd      (cmd),
         .occ      (occ),
         .prev_val (pv),
         .prev_lt  (pl),
         .next_val (nv),
         .val      (val[i]),
         .lt       (lt[i])
      );
   end

endmodule

`default_nettype wire

[test/testbench.sv]
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import bmhq_pkg::*;

   localparam int HEAP_DEPTH  = DEPTH_DEF;
   localparam int CYCLE_LIMIT = 200000;

   typedef struct packed {
      logic signed [KEY_W-1:0] key_out;
      logic [STAT_W-1:0]       status;
      logic [CNT_W-1:0]        count;
   } heap_result_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      start = 1'b0;
   logic                      busy;
   logic                      req_op = OP_INSERT;
   logic signed [KEY_W-1:0]   req_key_in = '0;
   logic                      csr_we = 1'b0;
   logic [LIMIT_W-1:0]        csr_wdata = '0;
   logic                      rsp_valid;
   logic signed [KEY_W-1:0]   rsp_key_out;
   logic [STAT_W-1:0]         rsp_status;
   logic [CNT_W-1:0]          rsp_count;

   // predictor state
   logic signed [KEY_W-1:0]   heap_mem [HEAP_DEPTH];
   int unsigned               heap_fill = 0;
   logic [LIMIT_W-1:0]        cap_reg = LIMIT_RESET;

   heap_result_type           pending_results[$];
   heap_result_type           want;
   int                        errors = 0;
   int                        cycle_count = 0;
   int                        sender_idle_pct = 0;
   int                        n_inserts = 0;
   int                        n_extracts = 0;
   int                        n_full = 0;
   int                        n_empty = 0;
   int                        n_responses = 0;

   binary_min_heap_queue_core #(.DEPTH(HEAP_DEPTH)) i_dut (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_op      (req_op),
      .req_key_in  (req_key_in),
      .csr_we      (csr_we),
      .csr_wdata   (csr_wdata),
      .rsp_valid   (rsp_valid),
      .rsp_key_out (rsp_key_out),
      .rsp_status  (rsp_status),
      .rsp_count   (rsp_count)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d responses outstanding", $time,
                  pending_results.size());
         $display("testbench NOT OK");
         $finish;
      end
   end

   // Applies one request to the heap model and returns the response it should give.
   function automatic void heap_apply(input logic op, input logic signed [KEY_W-1:0] key,
                                      output heap_result_type r);
      int unsigned             lim;
      int unsigned             pos;
      int unsigned             parent;
      int unsigned             best;
      int unsigned             lc;
      int unsigned             rc;
      int unsigned             guard;
      logic signed [KEY_W-1:0] tmp;
      bit                      done;
      r.key_out = '0;
      r.status  = ST_OK;
      lim = (cap_reg > HEAP_DEPTH) ? HEAP_DEPTH : cap_reg;
      if (op == OP_INSERT) begin
         n_inserts++;
         if (heap_fill >= lim) begin
            r.status = ST_FULL;
            n_full++;
         end else begin
            heap_mem[heap_fill] = key;
            pos = heap_fill;
            heap_fill++;
            done = 1'b0;
            guard = 0;
            // move up only while strictly smaller than the parent
            while (!done && pos > 0 && guard < HEAP_DEPTH) begin
               parent = (pos - 1) / 2;
               if (heap_mem[pos] < heap_mem[parent]) begin
                  tmp = heap_mem[pos];
                  heap_mem[pos] = heap_mem[parent];
                  heap_mem[parent] = tmp;
                  pos = parent;
               end else begin
                  done = 1'b1;
               end
               guard++;
            end
         end
      end else begin
         n_extracts++;
         if (heap_fill == 0) begin
            r.key_out = EMPTY_KEY;
            r.status  = ST_EMPTY;
            n_empty++;
         end else begin
            r.key_out = heap_mem[0];
            heap_fill--;
            heap_mem[0] = heap_mem[heap_fill];
            pos = 0;
            done = 1'b0;
            guard = 0;
            // left child wins a tie, stop when no child is strictly smaller
            while (!done && pos < heap_fill && guard < HEAP_DEPTH) begin
               best = pos;
               lc = 2 * pos + 1;
               rc = 2 * pos + 2;
               if (lc < heap_fill && heap_mem[lc] < heap_mem[best]) best = lc;
               if (rc < heap_fill && heap_mem[rc] < heap_mem[best]) best = rc;
               if (best == pos) begin
                  done = 1'b1;
               end else begin
                  tmp = heap_mem[pos];
                  heap_mem[pos] = heap_mem[best];
                  heap_mem[best] = tmp;
                  pos = best;
               end
               guard++;
            end
         end
      end
      r.count = CNT_W'(heap_fill);
   endfunction

   function automatic logic signed [KEY_W-1:0] rand_key();
      case ($urandom_range(3))
         0: return $urandom_range(16) - 8;   // narrow range, lots of ties
         1: case ($urandom_range(3))
               0: return 32'sh8000_0000;
               1: return 32'sh7fff_ffff;
               2: return 32'sd0;
               default: return -32'sd1;
            endcase
         default: return $urandom();
      endcase
   endfunction

   task automatic send_request(input logic op, input logic signed [KEY_W-1:0] key);
      heap_result_type r;
      while ($urandom_range(99) < sender_idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start      <= 1'b1;
      req_op     <= op;
      req_key_in <= key;
      @(posedge clock);
      while (busy) @(posedge clock);
      heap_apply(op, key, r);
      pending_results.push_back(r);
   endtask

   task automatic wait_drained();
      start <= 1'b0;
      @(posedge clock);
      while (pending_results.size() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   task automatic write_limit(input logic [LIMIT_W-1:0] value);
      wait_drained();
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
      cap_reg = value;
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected response: expected none, actual key %0d",
                     $time, rsp_key_out);
            errors++;
         end else begin
            want = pending_results.pop_front();
            n_responses++;
            if (rsp_key_out !== want.key_out) begin
               $display("%0t: key_out mismatch: expected %0d actual %0d",
                        $time, want.key_out, rsp_key_out);
               errors++;
            end
            if (rsp_status !== want.status) begin
               $display("%0t: status mismatch: expected %0d actual %0d",
                        $time, want.status, rsp_status);
               errors++;
            end
            if (rsp_count !== want.count) begin
               $display("%0t: count mismatch: expected %0d actual %0d",
                        $time, want.count, rsp_count);
               errors++;
            end
         end
      end
   end

   // runs at the reset value of the limit
   task automatic test_empty_extract();
      sender_idle_pct = 0;
      send_request(OP_EXTRACT, 32'sh7fff_ffff);
      send_request(OP_EXTRACT, 32'sh8000_0000);
   endtask

   task automatic test_extreme_keys();
      send_request(OP_INSERT, 32'sh7fff_ffff);
      send_request(OP_INSERT, 32'sh8000_0000);
      send_request(OP_INSERT, 32'sd0);
      send_request(OP_INSERT, -32'sd1);
      send_request(OP_INSERT, 32'sh8000_0000);
      repeat (6) send_request(OP_EXTRACT, 32'sd0);
   endtask

   task automatic test_full_at_limit();
      write_limit(7'd1);
      send_request(OP_INSERT, 32'sd7);
      send_request(OP_INSERT, 32'sd3);
      send_request(OP_EXTRACT, 32'sd0);
      send_request(OP_EXTRACT, 32'sd0);
      write_limit(7'd0);
      send_request(OP_INSERT, 32'sd4);
      send_request(OP_EXTRACT, 32'sd0);
   endtask

   // limit dropped under the fill: inserts refused, extracts still work
   task automatic test_lowered_limit();
      write_limit(7'd64);
      send_request(OP_INSERT, 32'sd5);
      send_request(OP_INSERT, 32'sd5);
      send_request(OP_INSERT, 32'sd2);
      send_request(OP_INSERT, 32'sd9);
      write_limit(7'd2);
      send_request(OP_INSERT, 32'sd1);
      send_request(OP_EXTRACT, 32'sd0);
      send_request(OP_EXTRACT, 32'sd0);
      send_request(OP_INSERT, 32'sd1);
      send_request(OP_EXTRACT, 32'sd0);
      send_request(OP_INSERT, 32'sd1);
      send_request(OP_EXTRACT, 32'sd0);
      send_request(OP_EXTRACT, 32'sd0);
   endtask

   task automatic test_fill_and_drain(input logic [LIMIT_W-1:0] limit, input int idle_pct);
      write_limit(limit);
      sender_idle_pct = idle_pct;
      repeat (HEAP_DEPTH + 2) send_request(OP_INSERT, rand_key());
      repeat (HEAP_DEPTH + 2) send_request(OP_EXTRACT, rand_key());
   endtask

   task automatic test_random_traffic(input int n, input logic [LIMIT_W-1:0] limit,
                                      input int idle_pct, input int insert_pct);
      write_limit(limit);
      sender_idle_pct = idle_pct;
      repeat (n) begin
         if ($urandom_range(99) < insert_pct) send_request(OP_INSERT, rand_key());
         else send_request(OP_EXTRACT, rand_key());
      end
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      test_empty_extract();
      test_extreme_keys();
      test_full_at_limit();
      test_lowered_limit();
      test_fill_and_drain(7'd127, 0);
      test_fill_and_drain(7'd64, 48);
      test_random_traffic(250, 7'd64, 0, 60);
      test_random_traffic(250, 7'd5, 48, 55);
      test_random_traffic(250, 7'd63, 11, 70);
      test_random_traffic(150, 7'd1, 0, 50);
      test_random_traffic(100, 7'd0, 11, 50);
      test_random_traffic(250, LIMIT_W'($urandom_range(127)), 48, 50);
      test_random_traffic(150, 7'd127, 11, 45);
      wait_drained();
      repeat (4) @(posedge clock);
      $display("Covered %0d inserts and %0d extracts, %0d responses checked,",
               n_inserts, n_extracts, n_responses);
      $display("with %0d refused inserts and %0d empty extracts over limits 0 to 127.",
               n_full, n_empty);
      if (errors == 0 && pending_results.size() == 0) begin
         $display("testbench OK");
      end else begin
         $display("testbench NOT OK");
      end
      $finish;
   end

endmodule
